// ===== hw/rtl/midpoint_line_rasterizer_assert.svh =====
// Assertion macros for the midpoint line rasterizer checker.
// Each macro expands to one labeled concurrent assertion clocked on i_clk
// and disabled while i_rst_n is low.
`ifndef MIDPOINT_LINE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_ASSERT_SVH

// Same-cycle implication
`define MLR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mlr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared codes and constants of the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

    // Operation code of an input transaction
    typedef logic t_op;
    localparam t_op OP_START = 1'b0;
    localparam t_op OP_STEP  = 1'b1;

    // Slope class of the active line
    typedef logic [1:0] t_slope;
    localparam t_slope SLOPE_SHALLOW_UP   = 2'd0;
    localparam t_slope SLOPE_SHALLOW_DOWN = 2'd1;
    localparam t_slope SLOPE_STEEP_UP     = 2'd2;
    localparam t_slope SLOPE_STEEP_DOWN   = 2'd3;

    // Decision variable carries this many bits above the coordinate width
    localparam int DEC_EXTRA_BITS = 4;

endpackage

// ===== hw/rtl/mlr_setup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlr_setup
// Line setup: orders the endpoints by x, picks the slope class and forms the
// initial decision value and its two increments.
// ----------------------------------------------------------------------------
module mlr_setup #(
    parameter int COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0]                          i_x_start,
    input  logic [COORD_BITS-1:0]                          i_y_start,
    input  logic [COORD_BITS-1:0]                          i_x_end,
    input  logic [COORD_BITS-1:0]                          i_y_end,
    output logic [COORD_BITS-1:0]                          o_x0,
    output logic [COORD_BITS-1:0]                          o_y0,
    output logic [COORD_BITS-1:0]                          o_x1,
    output logic [COORD_BITS-1:0]                          o_y1,
    output logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA_BITS-1:0] o_decision,
    output logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA_BITS-1:0] o_inc_diag,
    output logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA_BITS-1:0] o_inc_axial,
    output mlr_pkg::t_slope                                o_slope,
    output logic                                           o_active
);

    localparam int DW = COORD_BITS + mlr_pkg::DEC_EXTRA_BITS;

    logic                  swap;
    logic [COORD_BITS-1:0] b_u;
    logic signed [DW-1:0]  dv_a;
    logic signed [DW-1:0]  dv_b;
    logic signed [DW-1:0]  dv_dy;

    // Endpoint ordering so that x never falls
    assign swap = (i_x_end < i_x_start);
    assign o_x0 = swap ? i_x_end   : i_x_start;
    assign o_y0 = swap ? i_y_end   : i_y_start;
    assign o_x1 = swap ? i_x_start : i_x_end;
    assign o_y1 = swap ? i_y_start : i_y_end;

    // Deltas at the decision width, formed from zero-extended coordinates
    assign b_u   = o_x1 - o_x0;
    assign dv_b  = $signed({{mlr_pkg::DEC_EXTRA_BITS{1'b0}}, b_u});
    assign dv_dy = $signed({{mlr_pkg::DEC_EXTRA_BITS{1'b0}}, o_y1})
                 - $signed({{mlr_pkg::DEC_EXTRA_BITS{1'b0}}, o_y0});
    assign dv_a  = -dv_dy;

    // Slope class and initial decision terms
    always_comb begin
        if (!dv_dy[DW-1] && (dv_dy <= dv_b)) begin
            o_slope     = mlr_pkg::SLOPE_SHALLOW_UP;
            o_decision  = (dv_a <<< 1) + dv_b;
            o_inc_diag  = (dv_a + dv_b) <<< 1;
            o_inc_axial = dv_a <<< 1;
        end else if (dv_dy[DW-1] && (dv_a <= dv_b)) begin
            o_slope     = mlr_pkg::SLOPE_SHALLOW_DOWN;
            o_decision  = (dv_a <<< 1) - dv_b;
            o_inc_diag  = (dv_a - dv_b) <<< 1;
            o_inc_axial = dv_a <<< 1;
        end else if (dv_dy > dv_b) begin
            o_slope     = mlr_pkg::SLOPE_STEEP_UP;
            o_decision  = dv_a + (dv_b <<< 1);
            o_inc_diag  = (dv_a + dv_b) <<< 1;
            o_inc_axial = dv_b <<< 1;
        end else begin
            o_slope     = mlr_pkg::SLOPE_STEEP_DOWN;
            o_decision  = dv_a - (dv_b <<< 1);
            o_inc_diag  = (dv_a - dv_b) <<< 1;
            o_inc_axial = -(dv_b <<< 1);
        end
    end

    // Line continues past the start pixel
    always_comb begin
        case (o_slope)
            mlr_pkg::SLOPE_SHALLOW_UP,
            mlr_pkg::SLOPE_SHALLOW_DOWN: o_active = (o_x0 < o_x1);
            mlr_pkg::SLOPE_STEEP_UP:     o_active = (o_y0 < o_y1);
            default:                     o_active = (o_y0 > o_y1);
        endcase
    end

endmodule

// ===== hw/rtl/mlr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlr_core
// Line state registers and the single-step midpoint update. Produces the
// pixel of the current transaction combinationally from the input and state.
// ----------------------------------------------------------------------------
module mlr_core #(
    parameter int COORD_BITS = 10
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_en,
    input  mlr_pkg::t_op                                   i_operation,
    input  logic [COORD_BITS-1:0]                          i_init_x,
    input  logic [COORD_BITS-1:0]                          i_init_y,
    input  logic [COORD_BITS-1:0]                          i_init_tx,
    input  logic [COORD_BITS-1:0]                          i_init_ty,
    input  logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA_BITS-1:0] i_init_decision,
    input  logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA_BITS-1:0] i_init_inc_diag,
    input  logic signed [COORD_BITS+mlr_pkg::DEC_EXTRA_BITS-1:0] i_init_inc_axial,
    input  mlr_pkg::t_slope                                i_init_slope,
    input  logic                                           i_init_active,
    output logic                                           o_valid_res,
    output logic [COORD_BITS-1:0]                          o_pixel_x,
    output logic [COORD_BITS-1:0]                          o_pixel_y,
    output logic                                           o_last
);

    localparam int DW = COORD_BITS + mlr_pkg::DEC_EXTRA_BITS;

    // Line state
    logic [COORD_BITS-1:0] r_cur_x,    n_cur_x;
    logic [COORD_BITS-1:0] r_cur_y,    n_cur_y;
    logic [COORD_BITS-1:0] r_tgt_x,    n_tgt_x;
    logic [COORD_BITS-1:0] r_tgt_y,    n_tgt_y;
    logic signed [DW-1:0]  r_decision, n_decision;
    logic signed [DW-1:0]  r_inc_diag, n_inc_diag;
    logic signed [DW-1:0]  r_inc_axial, n_inc_axial;
    mlr_pkg::t_slope       r_slope,    n_slope;
    logic                  r_active,   n_active;

    // Step results
    logic                  diag;
    logic [COORD_BITS-1:0] x_inc;
    logic [COORD_BITS-1:0] y_inc;
    logic [COORD_BITS-1:0] y_dec;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;
    logic signed [DW-1:0]  step_decision;
    logic                  step_active;

    assign x_inc = r_cur_x + 1'b1;
    assign y_inc = r_cur_y + 1'b1;
    assign y_dec = r_cur_y - 1'b1;

    // Diagonal or axial move per slope class
    always_comb begin
        case (r_slope)
            mlr_pkg::SLOPE_SHALLOW_UP:   diag = r_decision < 0;
            mlr_pkg::SLOPE_SHALLOW_DOWN: diag = r_decision > 0;
            mlr_pkg::SLOPE_STEEP_UP:     diag = r_decision > 0;
            default:                     diag = r_decision <= 0;
        endcase
    end

    // One pixel step
    always_comb begin
        step_x = r_cur_x;
        step_y = r_cur_y;
        if (diag) begin
            step_x        = x_inc;
            step_y        = ((r_slope == mlr_pkg::SLOPE_SHALLOW_UP) ||
                             (r_slope == mlr_pkg::SLOPE_STEEP_UP)) ? y_inc : y_dec;
            step_decision = r_decision + r_inc_diag;
        end else begin
            case (r_slope)
                mlr_pkg::SLOPE_SHALLOW_UP,
                mlr_pkg::SLOPE_SHALLOW_DOWN: step_x = x_inc;
                mlr_pkg::SLOPE_STEEP_UP:     step_y = y_inc;
                default:                     step_y = y_dec;
            endcase
            step_decision = r_decision + r_inc_axial;
        end
    end

    // End test against the target
    always_comb begin
        case (r_slope)
            mlr_pkg::SLOPE_SHALLOW_UP,
            mlr_pkg::SLOPE_SHALLOW_DOWN: step_active = (step_x < r_tgt_x);
            mlr_pkg::SLOPE_STEEP_UP:     step_active = (step_y < r_tgt_y);
            default:                     step_active = (step_y > r_tgt_y);
        endcase
    end

    // Next state and pixel of the current transaction
    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_tgt_x     = r_tgt_x;
        n_tgt_y     = r_tgt_y;
        n_decision  = r_decision;
        n_inc_diag  = r_inc_diag;
        n_inc_axial = r_inc_axial;
        n_slope     = r_slope;
        n_active    = r_active;
        o_valid_res = 1'b0;
        o_pixel_x   = '0;
        o_pixel_y   = '0;
        o_last      = 1'b0;
        if (i_operation == mlr_pkg::OP_START) begin
            n_cur_x     = i_init_x;
            n_cur_y     = i_init_y;
            n_tgt_x     = i_init_tx;
            n_tgt_y     = i_init_ty;
            n_decision  = i_init_decision;
            n_inc_diag  = i_init_inc_diag;
            n_inc_axial = i_init_inc_axial;
            n_slope     = i_init_slope;
            n_active    = i_init_active;
            o_valid_res = 1'b1;
            o_pixel_x   = i_init_x;
            o_pixel_y   = i_init_y;
            o_last      = !i_init_active;
        end else if (r_active) begin
            n_cur_x     = step_x;
            n_cur_y     = step_y;
            n_decision  = step_decision;
            n_active    = step_active;
            o_valid_res = 1'b1;
            o_pixel_x   = step_x;
            o_pixel_y   = step_y;
            o_last      = !step_active;
        end
    end

    // State update on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_tgt_x     <= '0;
            r_tgt_y     <= '0;
            r_decision  <= '0;
            r_inc_diag  <= '0;
            r_inc_axial <= '0;
            r_slope     <= mlr_pkg::SLOPE_SHALLOW_UP;
            r_active    <= 1'b0;
        end else if (i_en) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_tgt_x     <= n_tgt_x;
            r_tgt_y     <= n_tgt_y;
            r_decision  <= n_decision;
            r_inc_diag  <= n_inc_diag;
            r_inc_axial <= n_inc_axial;
            r_slope     <= n_slope;
            r_active    <= n_active;
        end
    end

endmodule

// ===== hw/rtl/midpoint_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Midpoint line rasterizer: a start transaction loads a line and gives its
// first pixel, each step gives the next pixel or, with no line active, an empty result.
// ----------------------------------------------------------------------------
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+---------------------------------------------
//  input    | i_valid  | o_stall  | i_operation, i_x_start, i_y_start, i_x_end,
//           |          |          | i_y_end
//  output   | o_valid  | i_stall  | o_valid_res, o_pixel_x, o_pixel_y, o_last
//
//  One transaction per clock while o_stall is low; each result is registered in
//  the output or skid register. Setup and step are a single add and compare pass.
//  Reset (synchronous, i_rst_n low) clears the line state to idle and
//  empties the output register and skid register.
//  A stalled output fills the skid register; o_stall rises only once both
//  the output and skid registers hold results.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer #(
    parameter int COORD_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_valid_res,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last
);

    localparam int DW = COORD_BITS + mlr_pkg::DEC_EXTRA_BITS;

    logic                  accept_in;
    logic                  take_out;

    logic [COORD_BITS-1:0] su_x0;
    logic [COORD_BITS-1:0] su_y0;
    logic [COORD_BITS-1:0] su_x1;
    logic [COORD_BITS-1:0] su_y1;
    logic signed [DW-1:0]  su_decision;
    logic signed [DW-1:0]  su_inc_diag;
    logic signed [DW-1:0]  su_inc_axial;
    mlr_pkg::t_slope       su_slope;
    logic                  su_active;

    logic                  res_valid_res;
    logic [COORD_BITS-1:0] res_x;
    logic [COORD_BITS-1:0] res_y;
    logic                  res_last;

    // Output and skid registers
    logic                  r_out_v;
    logic                  r_out_valid_res;
    logic [COORD_BITS-1:0] r_out_x;
    logic [COORD_BITS-1:0] r_out_y;
    logic                  r_out_last;
    logic                  r_skid_v;
    logic                  r_skid_valid_res;
    logic [COORD_BITS-1:0] r_skid_x;
    logic [COORD_BITS-1:0] r_skid_y;
    logic                  r_skid_last;

    assign accept_in = i_valid && !r_skid_v;
    assign take_out  = r_out_v && !i_stall;

    // Line setup
    mlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_x_start   (i_x_start),
        .i_y_start   (i_y_start),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .o_x0        (su_x0),
        .o_y0        (su_y0),
        .o_x1        (su_x1),
        .o_y1        (su_y1),
        .o_decision  (su_decision),
        .o_inc_diag  (su_inc_diag),
        .o_inc_axial (su_inc_axial),
        .o_slope     (su_slope),
        .o_active    (su_active)
    );

    // Line state and step
    mlr_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (accept_in),
        .i_operation      (i_operation),
        .i_init_x         (su_x0),
        .i_init_y         (su_y0),
        .i_init_tx        (su_x1),
        .i_init_ty        (su_y1),
        .i_init_decision  (su_decision),
        .i_init_inc_diag  (su_inc_diag),
        .i_init_inc_axial (su_inc_axial),
        .i_init_slope     (su_slope),
        .i_init_active    (su_active),
        .o_valid_res      (res_valid_res),
        .o_pixel_x        (res_x),
        .o_pixel_y        (res_y),
        .o_last           (res_last)
    );

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (accept_in) begin
            if (!r_out_v || take_out) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take_out) begin
            r_out_v  <= r_skid_v;
            r_skid_v <= 1'b0;
        end
    end

    // Payload of the output and skid registers
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            if (!r_out_v || take_out) begin
                r_out_valid_res <= res_valid_res;
                r_out_x         <= res_x;
                r_out_y         <= res_y;
                r_out_last      <= res_last;
            end else begin
                r_skid_valid_res <= res_valid_res;
                r_skid_x         <= res_x;
                r_skid_y         <= res_y;
                r_skid_last      <= res_last;
            end
        end else if (take_out && r_skid_v) begin
            r_out_valid_res <= r_skid_valid_res;
            r_out_x         <= r_skid_x;
            r_out_y         <= r_skid_y;
            r_out_last      <= r_skid_last;
        end
    end

    assign o_stall     = r_skid_v;
    assign o_valid     = r_out_v;
    assign o_valid_res = r_out_valid_res;
    assign o_pixel_x   = r_out_x;
    assign o_pixel_y   = r_out_y;
    assign o_last      = r_out_last;

endmodule

// ===== hw/rtl/mlr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlr_checker
// Port-level checks of the midpoint line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "midpoint_line_rasterizer_assert.svh"

module mlr_checker #(
    parameter int COORD_BITS = 10
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  i_operation,
    input logic [COORD_BITS-1:0] i_x_start,
    input logic [COORD_BITS-1:0] i_y_start,
    input logic [COORD_BITS-1:0] i_x_end,
    input logic [COORD_BITS-1:0] i_y_end,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic                  o_valid_res,
    input logic [COORD_BITS-1:0] o_pixel_x,
    input logic [COORD_BITS-1:0] o_pixel_y,
    input logic                  o_last
);

    // Stalled output transaction holds
    `MLR_ASSERT_NEXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_valid_res) && $stable(o_pixel_x)
            && $stable(o_pixel_y) && $stable(o_last),
        "output changed while stalled")

    // An idle step carries a cleared pixel
    `MLR_ASSERT_IMPL(a_idle_zero, o_valid && !o_valid_res,
        (o_pixel_x == '0) && (o_pixel_y == '0) && !o_last,
        "idle step result not cleared")

    // Input stall only follows a stalled output
    `MLR_ASSERT_IMPL(a_stall_cause, $rose(o_stall), $past(o_valid && i_stall),
        "input stall without output stall")

    // A start with a free output shows its pixel in the next cycle
    `MLR_ASSERT_NEXT(a_start_pixel,
        i_valid && !o_stall && (i_operation == mlr_pkg::OP_START) && (!o_valid || !i_stall),
        o_valid && o_valid_res,
        "start transaction gave no pixel")

endmodule

bind midpoint_line_rasterizer mlr_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);

// ===== sim/midpoint_line_rasterizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_tb
// Self-checking bench for the midpoint line rasterizer. Lines of every slope
// class are drawn, restarted and overrun with steps. A scoreboard tracks the
// line state on its own and checks each output transaction in order.
// Traffic runs in several phases of sender gaps and receiver back-pressure.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_tb;

    localparam int CB           = 10;
    localparam int DW           = CB + mlr_pkg::DEC_EXTRA_BITS;
    localparam int COORD_MAX    = (1 << CB) - 1;
    localparam int RANDOM_ITEMS = 1550;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 400000;

    typedef logic [CB-1:0] t_coord;

    typedef struct packed {
        logic   valid_res;
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    // Independent copy of the line walker plus the queue of pixels in flight
    class raster_scoreboard;
        t_coord               cur_x, cur_y, tgt_x, tgt_y;
        logic signed [DW-1:0] dec, inc_diag, inc_axial;
        mlr_pkg::t_slope      slope;
        bit                   active;
        t_pixel               pixel_queue[$];
        int                   mismatches, checked, lines, idle_steps;

        function bit running();
            if (slope == mlr_pkg::SLOPE_SHALLOW_UP || slope == mlr_pkg::SLOPE_SHALLOW_DOWN)
                return cur_x < tgt_x;
            if (slope == mlr_pkg::SLOPE_STEEP_UP)
                return cur_y < tgt_y;
            return cur_y > tgt_y;
        endfunction

        function int pending();
            return pixel_queue.size();
        endfunction

        // Advance the walker by one accepted transaction
        function void note_input(mlr_pkg::t_op op, t_coord xs, t_coord ys,
                                 t_coord xe, t_coord ye);
            t_coord x0, y0, x1, y1;
            int     dx, dy;
            bit     diag;
            t_pixel px;
            px = '0;
            if (op == mlr_pkg::OP_START) begin
                x0 = xs; y0 = ys; x1 = xe; y1 = ye;
                if (xe < xs) begin
                    x0 = xe; y0 = ye; x1 = xs; y1 = ys;
                end
                dx = int'(x1) - int'(x0);
                dy = int'(y1) - int'(y0);
                if (dy >= 0 && dy <= dx) begin
                    slope     = mlr_pkg::SLOPE_SHALLOW_UP;
                    dec       = DW'(dx - 2 * dy);
                    inc_diag  = DW'(2 * (dx - dy));
                    inc_axial = DW'(-2 * dy);
                end else if (dy < 0 && dy >= -dx) begin
                    slope     = mlr_pkg::SLOPE_SHALLOW_DOWN;
                    dec       = DW'(-2 * dy - dx);
                    inc_diag  = DW'(-2 * dy - 2 * dx);
                    inc_axial = DW'(-2 * dy);
                end else if (dy > dx) begin
                    slope     = mlr_pkg::SLOPE_STEEP_UP;
                    dec       = DW'(2 * dx - dy);
                    inc_diag  = DW'(2 * (dx - dy));
                    inc_axial = DW'(2 * dx);
                end else begin
                    slope     = mlr_pkg::SLOPE_STEEP_DOWN;
                    dec       = DW'(-dy - 2 * dx);
                    inc_diag  = DW'(-2 * (dy + dx));
                    inc_axial = DW'(-2 * dx);
                end
                cur_x = x0; cur_y = y0; tgt_x = x1; tgt_y = y1;
                active = running();
                lines++;
                px.valid_res = 1'b1;
                px.x = cur_x; px.y = cur_y; px.last = !active;
            end else if (!active) begin
                // step with no line: empty result, state untouched
                idle_steps++;
            end else begin
                case (slope)
                    mlr_pkg::SLOPE_SHALLOW_UP:   diag = dec < 0;
                    mlr_pkg::SLOPE_SHALLOW_DOWN: diag = dec > 0;
                    mlr_pkg::SLOPE_STEEP_UP:     diag = dec > 0;
                    default:                     diag = dec <= 0;
                endcase
                if (diag) begin
                    cur_x = cur_x + 1'b1;
                    if (slope == mlr_pkg::SLOPE_SHALLOW_UP || slope == mlr_pkg::SLOPE_STEEP_UP)
                        cur_y = cur_y + 1'b1;
                    else
                        cur_y = cur_y - 1'b1;
                    dec = dec + inc_diag;
                end else begin
                    if (slope == mlr_pkg::SLOPE_SHALLOW_UP ||
                        slope == mlr_pkg::SLOPE_SHALLOW_DOWN)
                        cur_x = cur_x + 1'b1;
                    else if (slope == mlr_pkg::SLOPE_STEEP_UP)
                        cur_y = cur_y + 1'b1;
                    else
                        cur_y = cur_y - 1'b1;
                    dec = dec + inc_axial;
                end
                active = running();
                px.valid_res = 1'b1;
                px.x = cur_x; px.y = cur_y; px.last = !active;
            end
            pixel_queue.push_back(px);
        endfunction

        // Compare one output transaction against the oldest prediction
        function void check_result(t_pixel got);
            t_pixel want;
            if (pixel_queue.size() == 0) begin
                $display("%0t: unexpected pixel v=%0b (%0d,%0d) last=%0b",
                         $time, got.valid_res, got.x, got.y, got.last);
                mismatches++;
                return;
            end
            want = pixel_queue.pop_front();
            checked++;
            if (got.valid_res !== want.valid_res || got.x !== want.x ||
                got.y !== want.y || got.last !== want.last) begin
                $display("%0t: pixel mismatch: expected v=%0b (%0d,%0d) last=%0b",
                         $time, want.valid_res, want.x, want.y, want.last);
                $display("%0t:                 actual   v=%0b (%0d,%0d) last=%0b",
                         $time, got.valid_res, got.x, got.y, got.last);
                mismatches++;
            end
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    logic   i_operation;
    t_coord i_x_start, i_y_start, i_x_end, i_y_end;
    logic   o_valid;
    logic   i_stall;
    logic   o_valid_res;
    t_coord o_pixel_x, o_pixel_y;
    logic   o_last;

    raster_scoreboard sb;
    int src_idle_pct;
    int rcv_stall_pct;
    bit hold_req;
    int items_sent;
    int cycles;

    midpoint_line_rasterizer #(
        .COORD_BITS(CB)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_operation(i_operation),
        .i_x_start  (i_x_start),
        .i_y_start  (i_y_start),
        .i_x_end    (i_x_end),
        .i_y_end    (i_y_end),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_valid_res(o_valid_res),
        .o_pixel_x  (o_pixel_x),
        .o_pixel_y  (o_pixel_y),
        .o_last     (o_last)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycles, sb.pending());
            $display("midpoint_line_rasterizer_tb: errors");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && hold_req) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < rcv_stall_pct);
            end
        end
    end

    // Monitor both channels on the rising edge
    always @(posedge i_clk) begin
        t_pixel got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got.valid_res = o_valid_res;
                got.x = o_pixel_x; got.y = o_pixel_y; got.last = o_last;
                sb.check_result(got);
            end
            if (i_valid && !o_stall)
                sb.note_input(mlr_pkg::t_op'(i_operation), i_x_start, i_y_start,
                              i_x_end, i_y_end);
        end
    end

    // Offer one transaction, after a random gap, and wait for its acceptance
    task automatic send_item(mlr_pkg::t_op op, t_coord xs, t_coord ys,
                             t_coord xe, t_coord ye);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_operation <= op;
        i_x_start   <= xs;
        i_y_start   <= ys;
        i_x_end     <= xe;
        i_y_end     <= ye;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    // Step with junk in the endpoint fields, which the block ignores
    task automatic send_step();
        send_item(mlr_pkg::OP_STEP, t_coord'($urandom), t_coord'($urandom),
                  t_coord'($urandom), t_coord'($urandom));
    endtask

    task automatic run_line(t_coord x0, t_coord y0, t_coord x1, t_coord y1, int steps);
        send_item(mlr_pkg::OP_START, x0, y0, x1, y1);
        repeat (steps) send_step();
    endtask

    function automatic int pixel_span(t_coord x0, t_coord y0, t_coord x1, t_coord y1);
        int ax, ay;
        ax = (x1 > x0) ? int'(x1) - int'(x0) : int'(x0) - int'(x1);
        ay = (y1 > y0) ? int'(y1) - int'(y0) : int'(y0) - int'(y1);
        return (ax > ay) ? ax : ay;
    endfunction

    // Coordinate within spread of base, clipped to the screen
    function automatic t_coord near(int base, int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return t_coord'(v);
    endfunction

    // Coordinate hugging either border of the screen
    function automatic t_coord rim_coord();
        if ($urandom_range(1))
            return t_coord'($urandom_range(0, 6));
        return t_coord'($urandom_range(COORD_MAX - 6, COORD_MAX));
    endfunction

    // Stimulus
    initial begin
        t_coord x0, y0, x1, y1;
        int     kind, span, phase, cur_phase, rand_base;
        sb = new();
        items_sent    = 0;
        hold_req      = 1'b0;
        src_idle_pct  = 0;
        rcv_stall_pct = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = mlr_pkg::OP_START;
        i_x_start   = '0;
        i_y_start   = '0;
        i_x_end     = '0;
        i_y_end     = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle step, single point, each slope class, swap, restart
        send_step();
        run_line(5, 5, 5, 5, 1);
        run_line(0, 0, 3, 1, 4);
        run_line(COORD_MAX, 0, COORD_MAX - 3, 2, 3);
        run_line(0, COORD_MAX - 3, 0, COORD_MAX, 3);
        run_line(COORD_MAX - 1, 3, COORD_MAX, 0, 2);
        run_line(0, COORD_MAX, COORD_MAX, 0, 2);
        run_line(512, 341, 514, 341, 2);

        // Random lines, phase picked by progress
        rand_base = items_sent;
        cur_phase = -1;
        while (items_sent - rand_base < RANDOM_ITEMS) begin
            phase = (items_sent - rand_base) * 4 / RANDOM_ITEMS;
            if (phase != cur_phase) begin
                cur_phase = phase;
                case (phase)
                    0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  hold_req = 1'b1; end
                    1: begin src_idle_pct = 85; rcv_stall_pct = 0;  end
                    2: begin src_idle_pct = 0;  rcv_stall_pct = 85; end
                    default: begin src_idle_pct = 36; rcv_stall_pct = 36; end
                endcase
            end
            kind = $urandom_range(99);
            if (kind < 65) begin
                // short line, sometimes overrun by a few idle steps
                x0 = t_coord'($urandom_range(0, COORD_MAX));
                y0 = t_coord'($urandom_range(0, COORD_MAX));
                x1 = near(x0, 12);
                y1 = near(y0, 12);
                span = pixel_span(x0, y0, x1, y1);
                if ($urandom_range(3) == 0)
                    span += $urandom_range(1, 3);
                run_line(x0, y0, x1, y1, span);
            end else if (kind < 78) begin
                x0 = rim_coord(); y0 = rim_coord();
                x1 = rim_coord(); y1 = rim_coord();
                span = pixel_span(x0, y0, x1, y1);
                run_line(x0, y0, x1, y1, (span > 40) ? $urandom_range(0, 20) : span);
            end else if (kind < 90) begin
                // long line abandoned early by the next start
                x0 = t_coord'($urandom); y0 = t_coord'($urandom);
                x1 = t_coord'($urandom); y1 = t_coord'($urandom);
                run_line(x0, y0, x1, y1, $urandom_range(0, 20));
            end else if (kind < 95) begin
                // noise: random mix of starts and steps
                repeat ($urandom_range(1, 4))
                    send_item(mlr_pkg::t_op'($urandom_range(1)), t_coord'($urandom),
                              t_coord'($urandom), t_coord'($urandom), t_coord'($urandom));
            end else begin
                x0 = t_coord'($urandom_range(0, COORD_MAX));
                y0 = t_coord'($urandom_range(0, COORD_MAX));
                x1 = near(x0, 90);
                y1 = near(y0, 90);
                run_line(x0, y0, x1, y1, pixel_span(x0, y0, x1, y1));
            end
        end

        // Drain
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run covered %0d transactions: %0d lines started, %0d steps with no line",
                 items_sent, sb.lines, sb.idle_steps);
        $display("%0d results checked under gap and back-pressure phases, %0d mismatches",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("midpoint_line_rasterizer_tb: clean");
        else
            $display("midpoint_line_rasterizer_tb: errors");
        $finish;
    end

endmodule
